// ===== hdl/arabic_contextual_shaper_top_macros.svh =====
// Assertion macros shared by the checker of the Arabic contextual shaper.
`ifndef ARABIC_CONTEXTUAL_SHAPER_TOP_MACROS_SVH
`define ARABIC_CONTEXTUAL_SHAPER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ACS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("acs assertion failed");

// Implication that checks the consequent later than the antecedent
`define ACS_ASSERT_LAT2(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##2 (cons)) \
		else $error("acs latency assertion failed");

`endif

// ===== hdl/acs_pkg.sv =====
// Types, code tables and helper functions of the Arabic contextual shaper.
`default_nettype none

package acs_pkg;

	typedef logic [15:0] code_t;

	// One input transfer: the character and its two neighbors
	typedef struct packed {
		code_t self_code;
		code_t right_code;
		code_t left_code;
	} item_t;

	// One result transfer
	typedef struct packed {
		code_t shaped_code;
		code_t ligature_code;
	} result_t;

	localparam int FORM_ROWS = 42;
	localparam int FORM_COLS = 5;
	localparam int ROW_W     = $clog2(FORM_ROWS);

	// Column meaning within a form row
	localparam int COL_LAST   = 0;
	localparam int COL_FIRST  = 1;
	localparam int COL_MIDDLE = 2;
	localparam int COL_ALONE  = 3;

	localparam code_t LAM_CODE = 16'h0644;

	typedef code_t form_row_t [FORM_COLS];

	// Columns: last, first, middle, alone, base letter
	localparam form_row_t FORM_TAB [FORM_ROWS] = '{
		'{16'hFE80, 16'hFE80, 16'hFE80, 16'hFE80, 16'h0621},
		'{16'hFE82, 16'hFE81, 16'hFE82, 16'hFE81, 16'h0622},
		'{16'hFE84, 16'hFE83, 16'hFE84, 16'hFE83, 16'h0623},
		'{16'hFE86, 16'hFE85, 16'hFE86, 16'hFE85, 16'h0624},
		'{16'hFE88, 16'hFE87, 16'hFE88, 16'hFE87, 16'h0625},
		'{16'hFE8A, 16'hFE8B, 16'hFE8C, 16'hFE89, 16'h0626},
		'{16'hFE8E, 16'hFE8D, 16'hFE8E, 16'hFE8D, 16'h0627},
		'{16'hFE90, 16'hFE91, 16'hFE92, 16'hFE8F, 16'h0628},
		'{16'hFE94, 16'hFE93, 16'hFE94, 16'hFE93, 16'h0629},
		'{16'hFE96, 16'hFE97, 16'hFE98, 16'hFE95, 16'h062A},
		'{16'hFE9A, 16'hFE9B, 16'hFE9C, 16'hFE99, 16'h062B},
		'{16'hFE9E, 16'hFE9F, 16'hFEA0, 16'hFE9D, 16'h062C},
		'{16'hFEA2, 16'hFEA3, 16'hFEA4, 16'hFEA1, 16'h062D},
		'{16'hFEA6, 16'hFEA7, 16'hFEA8, 16'hFEA5, 16'h062E},
		'{16'hFEAA, 16'hFEA9, 16'hFEAA, 16'hFEA9, 16'h062F},
		'{16'hFEAC, 16'hFEAB, 16'hFEAC, 16'hFEAB, 16'h0630},
		'{16'hFEAE, 16'hFEAD, 16'hFEAE, 16'hFEAD, 16'h0631},
		'{16'hFEB0, 16'hFEAF, 16'hFEB0, 16'hFEAF, 16'h0632},
		'{16'hFEB2, 16'hFEB3, 16'hFEB4, 16'hFEB1, 16'h0633},
		'{16'hFEB6, 16'hFEB7, 16'hFEB8, 16'hFEB5, 16'h0634},
		'{16'hFEBA, 16'hFEBB, 16'hFEBC, 16'hFEB9, 16'h0635},
		'{16'hFEBE, 16'hFEBF, 16'hFEC0, 16'hFEBD, 16'h0636},
		'{16'hFEC2, 16'hFEC3, 16'hFEC4, 16'hFEC1, 16'h0637},
		'{16'hFEC6, 16'hFEC7, 16'hFEC8, 16'hFEC5, 16'h0638},
		'{16'hFECA, 16'hFECB, 16'hFECC, 16'hFEC9, 16'h0639},
		'{16'hFECE, 16'hFECF, 16'hFED0, 16'hFECD, 16'h063A},
		'{16'h063B, 16'h063B, 16'h063B, 16'h063B, 16'h063B},
		'{16'h063C, 16'h063C, 16'h063C, 16'h063C, 16'h063C},
		'{16'h063D, 16'h063D, 16'h063D, 16'h063D, 16'h063D},
		'{16'h063E, 16'h063E, 16'h063E, 16'h063E, 16'h063E},
		'{16'h063F, 16'h063F, 16'h063F, 16'h063F, 16'h063F},
		'{16'h0640, 16'h0640, 16'h0640, 16'h0640, 16'h0640},
		'{16'hFED2, 16'hFED3, 16'hFED4, 16'hFED1, 16'h0641},
		'{16'hFED6, 16'hFED7, 16'hFED8, 16'hFED5, 16'h0642},
		'{16'hFEDA, 16'hFEDB, 16'hFEDC, 16'hFED9, 16'h0643},
		'{16'hFEDE, 16'hFEDF, 16'hFEE0, 16'hFEDD, 16'h0644},
		'{16'hFEE2, 16'hFEE3, 16'hFEE4, 16'hFEE1, 16'h0645},
		'{16'hFEE6, 16'hFEE7, 16'hFEE8, 16'hFEE5, 16'h0646},
		'{16'hFEEA, 16'hFEEB, 16'hFEEC, 16'hFEE9, 16'h0647},
		'{16'hFEEE, 16'hFEED, 16'hFEEE, 16'hFEED, 16'h0648},
		'{16'hFEF0, 16'hFEF3, 16'hFEF4, 16'hFEEF, 16'h0649},
		'{16'hFEF2, 16'hFEF3, 16'hFEF4, 16'hFEF1, 16'h064A}
	};

	// Lam-alef ligatures: isolated and connected variant per alef
	localparam int ALEF_NUM = 4;
	typedef code_t lig_pair_t [2];
	localparam lig_pair_t LIG_TAB [ALEF_NUM] = '{
		'{16'hFEF5, 16'hFEF6},
		'{16'hFEF7, 16'hFEF8},
		'{16'hFEF9, 16'hFEFA},
		'{16'hFEFB, 16'hFEFC}
	};

	// Arabic blocks: base, presentation forms A and B
	function automatic logic is_arabic(code_t c);
		return (c >= 16'h0600 && c <= 16'h06FF) ||
			(c >= 16'hFB50 && c <= 16'hFDFF) ||
			(c >= 16'hFE70 && c <= 16'hFEFF);
	endfunction

	// Letters that do not join towards the following character
	function automatic logic is_nonjoin(code_t c);
		logic hit;
		unique case (c)
			16'h0621, 16'h0622, 16'h0623, 16'h0624, 16'h0625, 16'h0627,
			16'h0648, 16'h0632, 16'h0631, 16'h062F, 16'h0630: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

	// Letters that join towards the following character
	function automatic logic is_leftjoin(code_t c);
		logic hit;
		unique case (c)
			16'h062C, 16'h062D, 16'h062E, 16'h0647, 16'h0639, 16'h063A,
			16'h0641, 16'h0642, 16'h062B, 16'h0635, 16'h0636, 16'h0637,
			16'h0643, 16'h0645, 16'h0646, 16'h062A, 16'h0644, 16'h0628,
			16'h064A, 16'h0633, 16'h0634, 16'h0638, 16'h0626, 16'h0640: hit = 1'b1;
			default: hit = 1'b0;
		endcase
		return hit;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/acs_form.sv =====
// Contextual form lookup: row search in the form table and column choice.
`default_nettype none

module acs_form (
	input  wire acs_pkg::item_t item,
	output acs_pkg::code_t      shaped_code
);

	logic [acs_pkg::FORM_ROWS-1:0] row_hit;
	logic [acs_pkg::ROW_W-1:0]     row_idx;
	logic                          lj;
	logic                          rj;
	acs_pkg::code_t                form_last;
	acs_pkg::code_t                form_first;
	acs_pkg::code_t                form_middle;
	acs_pkg::code_t                form_alone;

	// Match against every column of every row
	always_comb begin
		for (int r = 0; r < acs_pkg::FORM_ROWS; r++) begin
			row_hit[r] = 1'b0;
			for (int k = 0; k < acs_pkg::FORM_COLS; k++) begin
				if (acs_pkg::FORM_TAB[r][k] == item.self_code) begin
					row_hit[r] = 1'b1;
				end
			end
		end
	end

	// Lowest matching row wins
	always_comb begin
		row_idx = '0;
		for (int r = acs_pkg::FORM_ROWS - 1; r >= 0; r--) begin
			if (row_hit[r]) begin
				row_idx = acs_pkg::ROW_W'(r);
			end
		end
	end

	assign form_last   = acs_pkg::FORM_TAB[row_idx][acs_pkg::COL_LAST];
	assign form_first  = acs_pkg::FORM_TAB[row_idx][acs_pkg::COL_FIRST];
	assign form_middle = acs_pkg::FORM_TAB[row_idx][acs_pkg::COL_MIDDLE];
	assign form_alone  = acs_pkg::FORM_TAB[row_idx][acs_pkg::COL_ALONE];

	// Joining on each side
	assign lj = acs_pkg::is_arabic(item.left_code) && !acs_pkg::is_nonjoin(item.left_code);
	assign rj = acs_pkg::is_arabic(item.right_code) && !acs_pkg::is_nonjoin(item.self_code);

	// Pick the form; unknown or non-Arabic codes pass through
	always_comb begin
		if (!(|row_hit) || !acs_pkg::is_arabic(item.self_code)) begin
			shaped_code = item.self_code;
		end else begin
			unique case ({lj, rj})
				2'b10:   shaped_code = form_last;
				2'b01:   shaped_code = form_first;
				2'b11:   shaped_code = form_middle;
				default: shaped_code = form_alone;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/acs_lig.sv =====
// Lam-alef ligature detection and variant choice.
`default_nettype none

module acs_lig (
	input  wire acs_pkg::item_t item,
	output acs_pkg::code_t      ligature_code
);

	logic is_lam;
	logic connected;

	// Lam followed by an Arabic right neighbor
	assign is_lam    = (item.self_code == acs_pkg::LAM_CODE) &&
		acs_pkg::is_arabic(item.right_code);
	assign connected = acs_pkg::is_leftjoin(item.left_code);

	// Alef variant selects the ligature row
	always_comb begin
		if (!is_lam) begin
			ligature_code = '0;
		end else begin
			unique case (item.right_code)
				16'h0622: ligature_code = acs_pkg::LIG_TAB[0][connected];
				16'h0623: ligature_code = acs_pkg::LIG_TAB[1][connected];
				16'h0625: ligature_code = acs_pkg::LIG_TAB[2][connected];
				16'h0627: ligature_code = acs_pkg::LIG_TAB[3][connected];
				default:  ligature_code = '0;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== hdl/arabic_contextual_shaper_top.sv =====
// Top level of the Arabic contextual shaper: input register, lookup, result register.
//
// channel   handshake        payload   transfer when
// --------  ---------------  --------  ------------------------------
// input     start / busy     item      start high and busy low at edge
// result    done (strobe)    result    edge ending the cycle done is high
//
// One character per cycle; busy stays low, so a transfer may come every cycle.
// Each character goes through the input register, then the form and ligature lookup
// into the result register. done is high for exactly one cycle per transfer.
// arst_n clears the valid flags; payload registers are not reset.
// The receiver cannot stall, so nothing is held back.
`default_nettype none

module arabic_contextual_shaper_top (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	input  wire acs_pkg::item_t   item,
	output logic                  done,
	output acs_pkg::result_t      result
);

	acs_pkg::item_t   item_s1;
	logic             valid_s1;
	acs_pkg::result_t result_s2;
	logic             valid_s2;
	acs_pkg::result_t lookup;

	assign busy = 1'b0;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			item_s1 <= item;
		end
	end

	// Lookup logic
	acs_form u_form (
		.item        (item_s1),
		.shaped_code (lookup.shaped_code)
	);

	acs_lig u_lig (
		.item          (item_s1),
		.ligature_code (lookup.ligature_code)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2 <= lookup;
		end
	end

	assign done   = valid_s2;
	assign result = result_s2;

endmodule

`default_nettype wire

// ===== hdl/acs_checker.sv =====
// Port-level checker for the Arabic contextual shaper and its bind.
`default_nettype none

`include "arabic_contextual_shaper_top_macros.svh"

module acs_checker (
	input wire                   clk,
	input wire                   arst_n,
	input wire                   start,
	input wire                   busy,
	input wire acs_pkg::item_t   item,
	input wire                   done,
	input wire acs_pkg::result_t result
);

	// Every accepted transfer yields exactly one strobe after the input and result registers
	`ACS_ASSERT_LAT2(a_done_follows, clk, arst_n, start && !busy, done)
	`ACS_ASSERT_LAT2(a_no_spurious, clk, arst_n, !(start && !busy), !done)

	// A ligature only comes from a lam with an alef on its right
	`ACS_ASSERT_IMP(a_lig_src, clk, arst_n, done && (result.ligature_code != 16'h0000),
		($past(item.self_code, 2) == acs_pkg::LAM_CODE) &&
		($past(item.right_code, 2) == 16'h0622 || $past(item.right_code, 2) == 16'h0623 ||
		 $past(item.right_code, 2) == 16'h0625 || $past(item.right_code, 2) == 16'h0627))

	// Non-Arabic characters pass through unchanged
	`ACS_ASSERT_IMP(a_passthru, clk, arst_n, done && !acs_pkg::is_arabic($past(item.self_code, 2)),
		result.shaped_code == $past(item.self_code, 2))

endmodule

bind arabic_contextual_shaper_top acs_checker u_acs_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.item   (item),
	.done   (done),
	.result (result)
);

`default_nettype wire
